// ===== rtl/core/greedy_nearest_neighbor_order_assert.svh =====
// Assertion macros shared by the ordering block.
// Each macro names the assertion, checks on the rising edge of clk and is
// disabled while arst_n is low.
`ifndef GREEDY_NEAREST_NEIGHBOR_ORDER_ASSERT_SVH
`define GREEDY_NEAREST_NEIGHBOR_ORDER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GNNO_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GNNO_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/gnno_pkg.sv =====
package gnno_pkg;

	// Store size and field widths.
	localparam int MAX_POINTS  = 64;
	localparam int COORD_WIDTH = 16;
	localparam int ID_WIDTH    = 16;
	localparam int IDX_W       = $clog2(MAX_POINTS);
	localparam int CNT_W       = $clog2(MAX_POINTS + 1);

	// Distance arithmetic widths: difference, square, sum of two squares.
	localparam int DIFF_W = COORD_WIDTH + 1;
	localparam int SQ_W   = 2 * DIFF_W;
	localparam int DIST_W = SQ_W + 1;

	// Queue sizes.
	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
	localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);
	localparam int OUTQ_DEPTH = 4;
	localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
	localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

	// Input opcodes.
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_RUN  = 1'b1;

	// Command kinds passed from the front end to the back end.
	typedef enum logic {
		CMD_STORE,
		CMD_RUN
	} cmd_kind_t;

	// Back end sequencer states.
	typedef enum logic [1:0] {
		B_IDLE,
		B_SCAN,
		B_EMIT
	} back_state_t;

	typedef struct packed {
		logic                          opcode;
		logic signed [COORD_WIDTH-1:0] x_coord;
		logic signed [COORD_WIDTH-1:0] y_coord;
		logic [ID_WIDTH-1:0]           hit_id;
	} in_item_t;

	typedef struct packed {
		logic [ID_WIDTH-1:0] ordered_id;
		logic                last;
		logic                overflow;
	} result_t;

	// For a store, num is the slot; for a run, num is the number of points.
	typedef struct packed {
		cmd_kind_t                     kind;
		logic signed [COORD_WIDTH-1:0] x;
		logic signed [COORD_WIDTH-1:0] y;
		logic [ID_WIDTH-1:0]           id;
		logic [CNT_W-1:0]              num;
		logic                          overflow;
	} cmd_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] x;
		logic signed [COORD_WIDTH-1:0] y;
		logic [ID_WIDTH-1:0]           id;
	} point_t;

endpackage

// ===== rtl/core/gnno_front.sv =====
module gnno_front import gnno_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  in_item_t item,
	output logic     full,
	output logic     cmd_push,
	output cmd_t     cmd,
	input  logic     cmd_full
);

	logic [CNT_W-1:0] count_q;
	logic             dropped_q;
	logic             accept;
	logic             is_run;
	logic             has_room;

	// An item is taken whenever the command queue has room.
	assign full     = cmd_full;
	assign accept   = push && !full;
	assign is_run   = (item.opcode == OP_RUN);
	assign has_room = (count_q < CNT_W'(MAX_POINTS));

	// Dropped loads never reach the back end.
	assign cmd_push = accept && (is_run || has_room);

	// Build the command: the slot for a store, the point count for a run.
	always_comb begin
		cmd.kind     = is_run ? CMD_RUN : CMD_STORE;
		cmd.x        = item.x_coord;
		cmd.y        = item.y_coord;
		cmd.id       = item.hit_id;
		cmd.num      = count_q;
		cmd.overflow = dropped_q;
	end

	// Track the fill level of the store and whether a load was dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			dropped_q <= 1'b0;
		end else if (accept) begin
			if (is_run) begin
				count_q   <= '0;
				dropped_q <= 1'b0;
			end else if (has_room) begin
				count_q <= count_q + CNT_W'(1);
			end else begin
				dropped_q <= 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/gnno_cmdq.sv =====
module gnno_cmdq import gnno_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t cmd,
	output logic full,
	input  logic pop,
	output cmd_t head,
	output logic empty
);

	cmd_t                  slots_q [CMDQ_DEPTH];
	logic [CMDQ_PTR_W-1:0] wr_ptr_q;
	logic [CMDQ_PTR_W-1:0] rd_ptr_q;
	logic [CMDQ_CNT_W-1:0] fill_q;
	logic                  do_push;
	logic                  do_pop;

	assign full    = (fill_q == CMDQ_CNT_W'(CMDQ_DEPTH));
	assign empty   = (fill_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = slots_q[rd_ptr_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 :
					wr_ptr_q + CMDQ_PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 :
					rd_ptr_q + CMDQ_PTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   fill_q <= fill_q + CMDQ_CNT_W'(1);
				2'b01:   fill_q <= fill_q - CMDQ_CNT_W'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= cmd;
		end
	end

endmodule

// ===== rtl/core/gnno_outq.sv =====
module gnno_outq import gnno_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t res,
	output logic    full,
	input  logic    pop,
	output result_t result,
	output logic    empty
);

	result_t               slots_q [OUTQ_DEPTH];
	logic [OUTQ_PTR_W-1:0] wr_ptr_q;
	logic [OUTQ_PTR_W-1:0] rd_ptr_q;
	logic [OUTQ_CNT_W-1:0] fill_q;
	logic                  do_push;
	logic                  do_pop;

	assign full    = (fill_q == OUTQ_CNT_W'(OUTQ_DEPTH));
	assign empty   = (fill_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign result  = slots_q[rd_ptr_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 :
					wr_ptr_q + OUTQ_PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 :
					rd_ptr_q + OUTQ_PTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   fill_q <= fill_q + OUTQ_CNT_W'(1);
				2'b01:   fill_q <= fill_q - OUTQ_CNT_W'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= res;
		end
	end

endmodule

// ===== rtl/core/gnno_back.sv =====
module gnno_back import gnno_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cmd_t    cmd,
	input  logic    cmd_empty,
	output logic    cmd_pop,
	output logic    res_push,
	output result_t res,
	input  logic    res_full
);

	// Sequencer and run state.
	back_state_t                   state_q;
	back_state_t                   state_d;
	logic [CNT_W-1:0]              count_q;
	logic [CNT_W-1:0]              emitted_q;
	logic [CNT_W-1:0]              rd_idx_q;
	logic                          overflow_q;
	logic signed [COORD_WIDTH-1:0] qx_q;
	logic signed [COORD_WIDTH-1:0] qy_q;
	logic [MAX_POINTS-1:0]         used_mask_q;

	// Point memory.
	point_t                        points_q [MAX_POINTS];

	// Distance pipeline.
	logic                          busy_s1, busy_s2, busy_s3;
	logic                          live_s1, live_s2, live_s3;
	logic [IDX_W-1:0]              idx_s1, idx_s2, idx_s3;
	point_t                        pt_s1, pt_s2, pt_s3;
	logic signed [DIFF_W-1:0]      dx_s2, dy_s2;
	logic [SQ_W-1:0]               sqx_s3, sqy_s3;

	// Best candidate of the current scan.
	logic                          found_q;
	logic [DIST_W-1:0]             best_d_q;
	logic [IDX_W-1:0]              best_idx_q;
	point_t                        best_pt_q;

	logic                          issue;
	logic                          scan_done;
	logic                          store_wr;
	logic                          start_run;
	logic                          emit_fire;
	logic                          last_hit;
	logic                          better;
	logic                          clean_idle;
	logic signed [SQ_W-1:0]        dxw, dyw;
	logic [DIST_W-1:0]             cand_d;

	// Command decode while idle.
	assign store_wr  = cmd_pop && (cmd.kind == CMD_STORE);
	assign start_run = cmd_pop && (cmd.kind == CMD_RUN) && (cmd.num != '0);

	// Scan control: one memory read per cycle, then the pipeline drains.
	assign issue     = (state_q == B_SCAN) && (rd_idx_q < count_q);
	assign scan_done = (state_q == B_SCAN) && !issue && !busy_s1 && !busy_s2 && !busy_s3;
	assign last_hit  = ((emitted_q + CNT_W'(1)) == count_q);
	assign emit_fire = res_push && !res_full;

	// Result for the nearest unused point.
	always_comb begin
		res.ordered_id = best_pt_q.id;
		res.last       = last_hit;
		res.overflow   = overflow_q;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (start_run) begin
					state_d = B_SCAN;
				end
			end
			B_SCAN: begin
				if (scan_done) begin
					state_d = B_EMIT;
				end
			end
			B_EMIT: begin
				if (emit_fire) begin
					state_d = last_hit ? B_IDLE : B_SCAN;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	// State outputs.
	always_comb begin
		cmd_pop  = 1'b0;
		res_push = 1'b0;
		unique case (state_q)
			B_IDLE:  cmd_pop  = !cmd_empty;
			B_SCAN:  cmd_pop  = 1'b0;
			B_EMIT:  res_push = 1'b1;
			default: cmd_pop  = 1'b0;
		endcase
	end

	// Sequencer, run counters and used mask.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			count_q     <= '0;
			emitted_q   <= '0;
			rd_idx_q    <= '0;
			overflow_q  <= 1'b0;
			used_mask_q <= '0;
			found_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start_run) begin
				count_q     <= cmd.num;
				overflow_q  <= cmd.overflow;
				emitted_q   <= '0;
				rd_idx_q    <= '0;
				used_mask_q <= '0;
				found_q     <= 1'b0;
			end else if (emit_fire) begin
				emitted_q <= emitted_q + CNT_W'(1);
				rd_idx_q  <= '0;
				found_q   <= 1'b0;
				if (last_hit) begin
					used_mask_q <= '0;
				end else begin
					used_mask_q[best_idx_q] <= 1'b1;
				end
			end else begin
				if (issue) begin
					rd_idx_q <= rd_idx_q + CNT_W'(1);
				end
				if (better) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	// Query position: the start position, then each emitted point.
	always_ff @(posedge clk) begin
		if (start_run) begin
			qx_q <= cmd.x;
			qy_q <= cmd.y;
		end else if (emit_fire) begin
			qx_q <= best_pt_q.x;
			qy_q <= best_pt_q.y;
		end
	end

	// Point memory: one write port for loads, one registered read port for scans.
	always_ff @(posedge clk) begin
		if (store_wr) begin
			points_q[cmd.num[IDX_W-1:0]] <= '{x: cmd.x, y: cmd.y, id: cmd.id};
		end
		pt_s1 <= points_q[rd_idx_q[IDX_W-1:0]];
	end

	// Pipeline occupancy; a live entry is one not yet used in this run.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
			busy_s2 <= 1'b0;
			busy_s3 <= 1'b0;
			live_s1 <= 1'b0;
			live_s2 <= 1'b0;
			live_s3 <= 1'b0;
		end else begin
			busy_s1 <= issue;
			busy_s2 <= busy_s1;
			busy_s3 <= busy_s2;
			live_s1 <= issue && !used_mask_q[rd_idx_q[IDX_W-1:0]];
			live_s2 <= live_s1;
			live_s3 <= live_s2;
		end
	end

	// Differences and squares.
	assign dxw = SQ_W'(dx_s2);
	assign dyw = SQ_W'(dy_s2);

	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx_q[IDX_W-1:0];
		idx_s2 <= idx_s1;
		idx_s3 <= idx_s2;
		pt_s2  <= pt_s1;
		pt_s3  <= pt_s2;
		dx_s2  <= DIFF_W'(pt_s1.x) - DIFF_W'(qx_q);
		dy_s2  <= DIFF_W'(pt_s1.y) - DIFF_W'(qy_q);
		sqx_s3 <= $unsigned(dxw * dxw);
		sqy_s3 <= $unsigned(dyw * dyw);
	end

	// Compare against the best so far; a strict less-than keeps the earliest slot.
	assign cand_d = DIST_W'(sqx_s3) + DIST_W'(sqy_s3);
	assign better = live_s3 && (!found_q || (cand_d < best_d_q));

	always_ff @(posedge clk) begin
		if (better) begin
			best_d_q   <= cand_d;
			best_idx_q <= idx_s3;
			best_pt_q  <= pt_s3;
		end
	end

	// Idle with no point marked as used.
	assign clean_idle = (state_q == B_IDLE) && (used_mask_q == '0);

	`include "greedy_nearest_neighbor_order_assert.svh"

	`GNNO_ASSERT(a_emit_has_candidate, state_q == B_EMIT, found_q, "emit without a candidate")
	`GNNO_ASSERT(a_emit_unused, state_q == B_EMIT, !used_mask_q[best_idx_q], "point emitted twice")
	`GNNO_ASSERT(a_best_in_store, found_q, CNT_W'(best_idx_q) < count_q, "candidate beyond store")
	`GNNO_ASSERT_NEXT(a_run_clean, emit_fire && last_hit, clean_idle, "run did not end clean")

endmodule

// ===== rtl/core/greedy_nearest_neighbor_order.sv =====
// Greedy nearest-neighbor ordering of up to MAX_POINTS 2D points (signed Q9.7).
// A load item stores one point with its hit id; loads beyond the store
// size are dropped and flag overflow on every result of the next run. A
// run item gives a start position: the block emits the id of the stored point
// nearest it (squared Euclidean distance, earliest loaded point on ties), then
// the unused point nearest the last one emitted, until all N stored points are
// out; the final result has last set, and the store is then empty. A run with
// no stored points emits nothing. For each result every stored point is read
// once through the single read port of the point memory, the last read then
// passes the three pipeline stages (read data, difference, square and
// compare), the sequencer then sees that the scan has drained and hands the
// result over, waiting while the output queue is full. Items queue in a
// two-entry command queue and results in a four-entry output queue, so both
// sides may stall independently.
module greedy_nearest_neighbor_order import gnno_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  in_item_t item,
	output logic     full,
	input  logic     pop,
	output result_t  result,
	output logic     empty
);

	logic    cmd_push;
	cmd_t    cmd;
	logic    cmd_full;
	cmd_t    cmd_head;
	logic    cmd_empty;
	logic    cmd_pop;
	logic    res_push;
	result_t res;
	logic    res_full;

	// Front end: classifies items and tracks the store fill level.
	gnno_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item     (item),
		.full     (full),
		.cmd_push (cmd_push),
		.cmd      (cmd),
		.cmd_full (cmd_full)
	);

	// Command queue between the front and back ends.
	gnno_cmdq u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.cmd    (cmd),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.head   (cmd_head),
		.empty  (cmd_empty)
	);

	// Back end: point memory and nearest-neighbor scan.
	gnno_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_head),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.res_push  (res_push),
		.res       (res),
		.res_full  (res_full)
	);

	// Result queue toward the consumer.
	gnno_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.res    (res),
		.full   (res_full),
		.pop    (pop),
		.result (result),
		.empty  (empty)
	);

endmodule
